// ----- hw/rtl/bre_pkg.sv -----
// Shared types, constants and helpers for the bitmap RLE8 decoder.
package bre_pkg;

  localparam int CFG_W     = 13;  // configuration register width
  localparam int BYTE_W    = 8;
  localparam int IDX_W     = 24;  // pixel index on the result port
  localparam int POS_W     = 25;  // linear position, holds frame end up to 2^24
  localparam int COL_W     = 13;  // column, below the effective width
  localparam int MODX_W    = 14;  // column plus a run length
  localparam int SKIP_W    = 21;  // delta skip: right + down * width
  localparam int PROD_W    = 2 * CFG_W;
  localparam int DIM_MAX_W = 17;  // holds the largest dimension cap

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int CMDQ_DEPTH_DEF = 2;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(25'h100_0000);

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // command kinds passed from parser to executor
  localparam logic [2:0] CMD_NOP   = 3'd0;
  localparam logic [2:0] CMD_RUN   = 3'd1;
  localparam logic [2:0] CMD_EOL   = 3'd2;
  localparam logic [2:0] CMD_EOB   = 3'd3;
  localparam logic [2:0] CMD_DELTA = 3'd4;

  typedef struct packed {
    logic [2:0]        kind;
    logic              fstart;
    logic [BYTE_W-1:0] cnt;    // run length, or right offset of a delta
    logic [BYTE_W-1:0] val;
    logic [SKIP_W-1:0] skip;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [MODX_W-1:0] x;
  } mod_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [COL_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [DIM_MAX_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (DIM_MAX_W'(v) > maxv) begin
      r = maxv[CFG_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/bmp_rle8_decoder.sv -----
// Bitmap RLE8 decoder top level: configuration registers, parser, queue, column reduction unit, executor.
// A run result passes through the command queue entry and the result register after its
// byte is accepted; an end-of-line result follows its column reduction.
// Each run, literal pixel or delta also waits in the executor for the column reduction
// unit, which needs extra restoring steps when the column wraps by more than one row.
// Reset (rst_n low, synchronous): parser, position and queue clear, both dimensions read 1.
module bmp_rle8_decoder #(
  parameter int MAX_WIDTH  = bre_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bre_pkg::MAX_HEIGHT_DEF,
  parameter int CMDQ_DEPTH = bre_pkg::CMDQ_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [bre_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bre_pkg::BYTE_W-1:0] in_code_byte,
  input  logic                       in_frame_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bre_pkg::IDX_W-1:0]  out_pixel_index,
  output logic [bre_pkg::BYTE_W-1:0] out_run_length,
  output logic [bre_pkg::BYTE_W-1:0] out_pixel_value,
  output logic                       out_frame_done
);

  logic [bre_pkg::CFG_W-1:0] width_r, height_r;
  logic [bre_pkg::CFG_W-1:0] eff_w, eff_h;
  logic                      q_full, q_push, q_pop, q_valid;
  bre_pkg::cmd_t             q_cmd, q_head;
  bre_pkg::mod_req_t         mod_req;
  bre_pkg::mod_rsp_t         mod_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bre_pkg::CFG_W'(1);
      height_r <= bre_pkg::CFG_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bre_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        bre_pkg::REG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // zero reads as one, oversize reads as the cap
  assign eff_w = bre_pkg::clamp_dim(width_r, bre_pkg::DIM_MAX_W'(MAX_WIDTH));
  assign eff_h = bre_pkg::clamp_dim(height_r, bre_pkg::DIM_MAX_W'(MAX_HEIGHT));

  bre_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_code_byte   (in_code_byte),
    .in_frame_start (in_frame_start),
    .in_stall       (in_stall),
    .eff_w          (eff_w),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  bre_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  bre_colmod u_colmod (
    .clk   (clk),
    .rst_n (rst_n),
    .eff_w (eff_w),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  bre_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .eff_w           (eff_w),
    .eff_h           (eff_h),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .mod_req         (mod_req),
    .mod_rsp         (mod_rsp),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_run_length  (out_run_length),
    .out_pixel_value (out_pixel_value),
    .out_frame_done  (out_frame_done)
  );

endmodule

// ----- hw/rtl/bre_front.sv -----
// Byte parser: accepts stream bytes and turns each into one command.
module bre_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [bre_pkg::BYTE_W-1:0] in_code_byte,
  input  logic                       in_frame_start,
  output logic                       in_stall,
  input  logic [bre_pkg::CFG_W-1:0]  eff_w,
  input  logic                       q_full,
  output logic                       q_push,
  output bre_pkg::cmd_t              q_cmd
);

  localparam logic [2:0] PH_COUNT   = 3'd0;
  localparam logic [2:0] PH_VALUE   = 3'd1;
  localparam logic [2:0] PH_ESCAPE  = 3'd2;
  localparam logic [2:0] PH_RIGHT   = 3'd3;
  localparam logic [2:0] PH_DOWN    = 3'd4;
  localparam logic [2:0] PH_LITERAL = 3'd5;
  localparam logic [2:0] PH_PAD     = 3'd6;

  localparam int BW = bre_pkg::BYTE_W;
  localparam int SW = bre_pkg::SKIP_W;

  logic [2:0]    phase_r, phase_nxt, ph_e;
  logic [BW-1:0] count_r, count_nxt, count_e;
  logic [BW-1:0] right_r, right_nxt, right_e;
  logic [BW-1:0] left_r, left_nxt, left_e, left_dec;
  logic          pad_r, pad_nxt, pad_e;
  logic          accept;
  logic [SW-1:0] down_skip;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign down_skip = SW'(in_code_byte) * SW'(eff_w);

  always_comb begin
    // frame start clears the parser before the byte is looked at
    ph_e    = in_frame_start ? PH_COUNT : phase_r;
    count_e = in_frame_start ? '0 : count_r;
    right_e = in_frame_start ? '0 : right_r;
    left_e  = in_frame_start ? '0 : left_r;
    pad_e   = in_frame_start ? 1'b0 : pad_r;
    left_dec = left_e - BW'(1);

    phase_nxt = ph_e;
    count_nxt = count_e;
    right_nxt = right_e;
    left_nxt  = left_e;
    pad_nxt   = pad_e;

    q_cmd        = '0;
    q_cmd.kind   = bre_pkg::CMD_NOP;
    q_cmd.fstart = in_frame_start;
    q_cmd.val    = in_code_byte;

    case (ph_e)
      PH_COUNT: begin
        if (in_code_byte == '0) begin
          phase_nxt = PH_ESCAPE;
        end else begin
          count_nxt = in_code_byte;
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        phase_nxt  = PH_COUNT;
        q_cmd.kind = bre_pkg::CMD_RUN;
        q_cmd.cnt  = count_e;
      end
      PH_ESCAPE: begin
        phase_nxt = PH_COUNT;
        if (in_code_byte == 8'h00) begin
          q_cmd.kind = bre_pkg::CMD_EOL;
        end else if (in_code_byte == 8'h01) begin
          q_cmd.kind = bre_pkg::CMD_EOB;
        end else if (in_code_byte == 8'h02) begin
          phase_nxt = PH_RIGHT;
        end else begin
          left_nxt  = in_code_byte;
          pad_nxt   = in_code_byte[0];
          phase_nxt = PH_LITERAL;
        end
      end
      PH_RIGHT: begin
        right_nxt = in_code_byte;
        phase_nxt = PH_DOWN;
      end
      PH_DOWN: begin
        phase_nxt  = PH_COUNT;
        q_cmd.kind = bre_pkg::CMD_DELTA;
        q_cmd.cnt  = right_e;
        q_cmd.skip = down_skip + SW'(right_e);
      end
      PH_LITERAL: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = pad_e ? PH_PAD : PH_COUNT;
        end
        q_cmd.kind = bre_pkg::CMD_RUN;
        q_cmd.cnt  = BW'(1);
      end
      PH_PAD: begin
        phase_nxt = PH_COUNT;
      end
      default: begin
        phase_nxt = PH_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      count_r <= '0;
      right_r <= '0;
      left_r  <= '0;
      pad_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      right_r <= right_nxt;
      left_r  <= left_nxt;
      pad_r   <= pad_nxt;
    end
  end

endmodule

// ----- hw/rtl/bre_cmdq.sv -----
// Short command queue between parser and executor.
module bre_cmdq #(
  parameter int DEPTH = bre_pkg::CMDQ_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bre_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output bre_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bre_pkg::cmd_t    entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("command popped from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("command pushed into full queue");

endmodule

// ----- hw/rtl/bre_colmod.sv -----
// Column reduction unit: remainder of a column sum by the frame width.
module bre_colmod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [bre_pkg::CFG_W-1:0] eff_w,
  input  bre_pkg::mod_req_t         req,
  output bre_pkg::mod_rsp_t         rsp
);

  localparam int XW = bre_pkg::MODX_W;
  localparam int TW = XW + bre_pkg::CFG_W;
  localparam int KW = $clog2(XW);

  logic [XW-1:0] rem_r;
  logic [KW-1:0] k_r;
  logic          busy_r;
  logic          near;
  logic [TW-1:0] trial;

  // below twice the width one subtract finishes it
  assign near  = ({1'b0, rem_r} < {1'b0, eff_w, 1'b0});
  assign trial = TW'(eff_w) << k_r;

  assign rsp.busy = busy_r;
  assign rsp.done = busy_r && near;
  assign rsp.rem  = (rem_r >= XW'(eff_w)) ? bre_pkg::COL_W'(rem_r - XW'(eff_w))
                                           : bre_pkg::COL_W'(rem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
      k_r    <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      rem_r  <= req.x;
      k_r    <= KW'(XW - 1);
    end else if (rsp.done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      // restoring step, one shifted width per cycle
      if (TW'(rem_r) >= trial) begin
        rem_r <= rem_r - trial[XW-1:0];
      end
      k_r <= k_r - KW'(1);
    end
  end

endmodule

// ----- hw/rtl/bre_back.sv -----
// Command executor: position, column, clipping and the result register.
module bre_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bre_pkg::CFG_W-1:0]  eff_w,
  input  logic [bre_pkg::CFG_W-1:0]  eff_h,
  input  logic                       q_valid,
  input  bre_pkg::cmd_t              q_head,
  output logic                       q_pop,
  output bre_pkg::mod_req_t          mod_req,
  input  bre_pkg::mod_rsp_t          mod_rsp,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [bre_pkg::IDX_W-1:0]  out_pixel_index,
  output logic [bre_pkg::BYTE_W-1:0] out_run_length,
  output logic [bre_pkg::BYTE_W-1:0] out_pixel_value,
  output logic                       out_frame_done
);

  localparam int PW = bre_pkg::POS_W;
  localparam int CW = bre_pkg::COL_W;
  localparam int XW = bre_pkg::MODX_W;
  localparam int BW = bre_pkg::BYTE_W;

  localparam logic ST_EXEC = 1'b0;
  localparam logic ST_MOD  = 1'b1;

  localparam logic [1:0] MK_RUN   = 2'd0;
  localparam logic [1:0] MK_EOL   = 2'd1;
  localparam logic [1:0] MK_DELTA = 2'd2;

  logic                      st_r, st_nxt;
  logic [1:0]                mk_r, mk_nxt;
  logic [PW-1:0]             pos_r, pos_nxt, pos_e;
  logic [CW-1:0]             col_r, col_nxt, col_e;
  logic                      rjf_r, rjf_nxt, rjf_e;
  logic                      fin_r, fin_nxt, fin_e;
  logic [PW-1:0]             frame_end_r;
  logic [bre_pkg::PROD_W-1:0] area;

  logic                      out_valid_r;
  logic [bre_pkg::IDX_W-1:0] o_idx_r, o_idx;
  logic [BW-1:0]             o_len_r, o_len, o_val_r, o_val;
  logic                      o_done_r, o_done;
  logic                      out_load, out_free;

  logic [PW-1:0]             avail, sum;
  logic [BW-1:0]             n;
  logic [CW-1:0]             adv;

  assign area = bre_pkg::PROD_W'(eff_w) * bre_pkg::PROD_W'(eff_h);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_end_r <= PW'(1);
    end else begin
      frame_end_r <= (area > bre_pkg::PROD_W'(bre_pkg::POS_LIMIT)) ? bre_pkg::POS_LIMIT
                                                                   : area[PW-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    pos_e = q_head.fstart ? '0 : pos_r;
    col_e = q_head.fstart ? '0 : col_r;
    rjf_e = q_head.fstart ? 1'b0 : rjf_r;
    fin_e = q_head.fstart ? 1'b0 : fin_r;

    avail = frame_end_r - pos_e;
    n     = (PW'(q_head.cnt) < avail) ? q_head.cnt : avail[BW-1:0];
    adv   = eff_w - mod_rsp.rem;
    sum   = '0;

    st_nxt  = st_r;
    mk_nxt  = mk_r;
    pos_nxt = pos_r;
    col_nxt = col_r;
    rjf_nxt = rjf_r;
    fin_nxt = fin_r;

    q_pop       = 1'b0;
    mod_req     = '0;
    out_load    = 1'b0;
    o_idx       = '0;
    o_len       = '0;
    o_val       = '0;
    o_done      = 1'b0;

    case (st_r)
      ST_EXEC: begin
        // only start a command when its result has a free slot
        if (q_valid && out_free) begin
          q_pop   = 1'b1;
          pos_nxt = pos_e;
          col_nxt = col_e;
          rjf_nxt = rjf_e;
          fin_nxt = fin_e;
          if (fin_e) begin
            // finished frame: bytes ignored until the next frame start
          end else if (pos_e >= frame_end_r) begin
            out_load = 1'b1;
            o_done   = 1'b1;
            fin_nxt  = 1'b1;
          end else begin
            case (q_head.kind)
              bre_pkg::CMD_RUN: begin
                pos_nxt     = pos_e + PW'(n);
                out_load    = 1'b1;
                o_idx       = pos_e[bre_pkg::IDX_W-1:0];
                o_len       = n;
                o_val       = q_head.val;
                o_done      = (pos_nxt >= frame_end_r);
                fin_nxt     = o_done;
                mod_req.start = 1'b1;
                mod_req.x   = XW'(col_e) + XW'(n);
                mk_nxt      = MK_RUN;
                st_nxt      = ST_MOD;
              end
              bre_pkg::CMD_EOL: begin
                if (rjf_e) begin
                  rjf_nxt = 1'b0;
                end else begin
                  mod_req.start = 1'b1;
                  mod_req.x     = XW'(col_e);
                  mk_nxt        = MK_EOL;
                  st_nxt        = ST_MOD;
                end
              end
              bre_pkg::CMD_EOB: begin
                out_load = 1'b1;
                o_done   = 1'b1;
                fin_nxt  = 1'b1;
              end
              bre_pkg::CMD_DELTA: begin
                rjf_nxt = 1'b0;
                sum     = pos_e + PW'(q_head.skip);
                pos_nxt = (sum > frame_end_r) ? frame_end_r : sum;
                if (pos_nxt >= frame_end_r) begin
                  out_load = 1'b1;
                  o_done   = 1'b1;
                  fin_nxt  = 1'b1;
                end
                mod_req.start = 1'b1;
                mod_req.x     = XW'(col_e) + XW'(q_head.cnt);
                mk_nxt        = MK_DELTA;
                st_nxt        = ST_MOD;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_MOD: begin
        if (mod_rsp.done) begin
          st_nxt = ST_EXEC;
          case (mk_r)
            MK_RUN: begin
              col_nxt = mod_rsp.rem;
              rjf_nxt = (mod_rsp.rem == '0);
            end
            MK_EOL: begin
              // step to the next row start, column lands on zero
              sum     = pos_r + PW'(adv);
              pos_nxt = (sum > frame_end_r) ? frame_end_r : sum;
              col_nxt = '0;
              if (pos_nxt >= frame_end_r) begin
                out_load = 1'b1;
                o_done   = 1'b1;
                fin_nxt  = 1'b1;
              end
            end
            MK_DELTA: begin
              col_nxt = mod_rsp.rem;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        st_nxt = ST_EXEC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_EXEC;
      mk_r  <= MK_RUN;
      pos_r <= '0;
      col_r <= '0;
      rjf_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      mk_r  <= mk_nxt;
      pos_r <= pos_nxt;
      col_r <= col_nxt;
      rjf_r <= rjf_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_idx_r  <= o_idx;
      o_len_r  <= o_len;
      o_val_r  <= o_val;
      o_done_r <= o_done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = o_idx_r;
  assign out_run_length  = o_len_r;
  assign out_pixel_value = o_val_r;
  assign out_frame_done  = o_done_r;

  a_mod_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MOD) |-> mod_rsp.busy)
    else $error("waiting on column unit that is not busy");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_valid_r && out_stall))
    else $error("result overwrites a beat still held");

  a_mod_result_eol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (st_r == ST_MOD)) |-> (mk_r == MK_EOL))
    else $error("result from column stage for a command other than end-of-line");

endmodule

// ----- verif/bmp_rle8_decoder_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bmp_rle8_decoder: RLE8 byte streams in, predicted pixel runs out.
module bmp_rle8_decoder_tb;

  localparam int BYTE_W         = bre_pkg::BYTE_W;
  localparam int CFG_W          = bre_pkg::CFG_W;
  localparam int IDX_W          = bre_pkg::IDX_W;
  localparam int MAX_WIDTH_DEF  = bre_pkg::MAX_WIDTH_DEF;
  localparam int MAX_HEIGHT_DEF = bre_pkg::MAX_HEIGHT_DEF;
  localparam logic [bre_pkg::POS_W-1:0] POS_LIMIT = bre_pkg::POS_LIMIT;
  localparam logic REG_FRAME_WIDTH  = bre_pkg::REG_FRAME_WIDTH;
  localparam logic REG_FRAME_HEIGHT = bre_pkg::REG_FRAME_HEIGHT;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PRINT_CAP     = 200;

  localparam logic [BYTE_W-1:0] ESC_MARK  = 8'h00;
  localparam logic [BYTE_W-1:0] ESC_EOL   = 8'h00;
  localparam logic [BYTE_W-1:0] ESC_EOB   = 8'h01;
  localparam logic [BYTE_W-1:0] ESC_DELTA = 8'h02;

  typedef enum logic [2:0] {
    SEEK_COUNT, SEEK_VALUE, SEEK_ESCAPE, SEEK_RIGHT, SEEK_DOWN, IN_LITERAL, SKIP_PAD
  } parse_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] val;
    logic              done;
  } pixel_run_t;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              fstart;
    logic              hold;   // wait for all runs to drain before presenting
  } stream_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_code_byte = '0;
  logic              in_frame_start = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [IDX_W-1:0]  out_pixel_index;
  logic [BYTE_W-1:0] out_run_length;
  logic [BYTE_W-1:0] out_pixel_value;
  logic              out_frame_done;

  bmp_rle8_decoder uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_code_byte    (in_code_byte),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_run_length  (out_run_length),
    .out_pixel_value (out_pixel_value),
    .out_frame_done  (out_frame_done)
  );

  always #5 clk = ~clk;

  stream_byte_t pending[$];
  pixel_run_t   expected_runs[$];
  int unsigned  items_made = 0;
  int unsigned  fail_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  quiet_in = 0, quiet_out = 0;
  int unsigned  gap_left = 0, stall_left = 0;
  logic         start_next = 1'b0, hold_next = 1'b0;

  // decoder shadow state
  logic [CFG_W-1:0]  width_reg = CFG_W'(1), height_reg = CFG_W'(1);
  parse_t            phase = SEEK_COUNT;
  logic [BYTE_W-1:0] run_count = '0, right_skip = '0, lits_left = '0;
  logic              pad_pending = 1'b0, filled_row = 1'b0, finished = 1'b0;
  int unsigned       pos = 0, col = 0;

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v, input int unsigned cap);
    if (v == '0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  function automatic int unsigned frame_limit();
    longint unsigned e;
    e = longint'(eff_dim(width_reg, MAX_WIDTH_DEF)) * eff_dim(height_reg, MAX_HEIGHT_DEF);
    if (e > POS_LIMIT) e = POS_LIMIT;
    return 32'(e);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte(input int unsigned lo, input int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic clear_decode();
    phase = SEEK_COUNT;
    run_count = '0;
    right_skip = '0;
    lits_left = '0;
    pad_pending = 1'b0;
    pos = 0;
    col = 0;
    filled_row = 1'b0;
    finished = 1'b0;
  endtask

  task automatic step_pos(input int unsigned n, input int unsigned lim);
    int unsigned w;
    longint unsigned p;
    w = eff_dim(width_reg, MAX_WIDTH_DEF);
    p = longint'(pos) + n;
    if (p > lim) p = lim;
    pos = 32'(p);
    col = ((col % w) + n) % w;
  endtask

  task automatic mark_done();
    pixel_run_t r;
    r = '0;
    r.done = 1'b1;
    finished = 1'b1;
    expected_runs.push_back(r);
  endtask

  task automatic emit_run(input int unsigned len, input logic [BYTE_W-1:0] v,
                          input int unsigned lim);
    pixel_run_t r;
    int unsigned n;
    n = (len < lim - pos) ? len : lim - pos;
    r.idx = pos[IDX_W-1:0];
    r.len = n[BYTE_W-1:0];
    r.val = v;
    step_pos(n, lim);
    filled_row = (col == 0);
    if (pos >= lim) finished = 1'b1;
    r.done = finished;
    expected_runs.push_back(r);
  endtask

  // one accepted stream byte: update the shadow decoder and queue any run it produces
  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic fs);
    int unsigned lim, w;
    if (fs) clear_decode();
    if (!finished) begin
      lim = frame_limit();
      w = eff_dim(width_reg, MAX_WIDTH_DEF);
      if (pos >= lim) begin
        mark_done();
      end else begin
        case (phase)
          SEEK_COUNT: begin
            if (b == ESC_MARK) begin
              phase = SEEK_ESCAPE;
            end else begin
              run_count = b;
              phase = SEEK_VALUE;
            end
          end
          SEEK_VALUE: begin
            phase = SEEK_COUNT;
            emit_run(run_count, b, lim);
          end
          SEEK_ESCAPE: begin
            phase = SEEK_COUNT;
            if (b == ESC_EOL) begin
              // a row that was just filled already sits at the next row start
              if (filled_row) begin
                filled_row = 1'b0;
              end else begin
                step_pos(w - (col % w), lim);
                if (pos >= lim) mark_done();
              end
            end else if (b == ESC_EOB) begin
              mark_done();
            end else if (b == ESC_DELTA) begin
              phase = SEEK_RIGHT;
            end else begin
              lits_left = b;
              pad_pending = b[0];
              phase = IN_LITERAL;
            end
          end
          SEEK_RIGHT: begin
            right_skip = b;
            phase = SEEK_DOWN;
          end
          SEEK_DOWN: begin
            phase = SEEK_COUNT;
            filled_row = 1'b0;
            step_pos(right_skip + b * w, lim);
            if (pos >= lim) mark_done();
          end
          IN_LITERAL: begin
            lits_left = lits_left - 8'd1;
            if (lits_left == '0) phase = pad_pending ? SKIP_PAD : SEEK_COUNT;
            emit_run(1, b, lim);
          end
          default: phase = SEEK_COUNT;
        endcase
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("run mismatch at %0t: %s", $time, msg);
  endtask

  task automatic draw_gap(inout int unsigned quiet, output int unsigned gap);
    int unsigned r;
    if (quiet != 0) begin
      quiet--;
      gap = 0;
    end else begin
      if ($urandom_range(63, 0) == 0) quiet = $urandom_range(80, 20);
      r = $urandom_range(99, 0);
      if (r < 55) gap = 0;
      else if (r < 85) gap = $urandom_range(3, 1);
      else if (r < 97) gap = $urandom_range(12, 4);
      else gap = $urandom_range(60, 20);
    end
  endtask

  // driver: presents pending bytes, predicts on each accepted beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_code_byte, in_frame_start);
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].hold && expected_runs.size() != 0)) begin
          in_valid       <= 1'b1;
          in_code_byte   <= pending[0].code;
          in_frame_start <= pending[0].fstart;
          void'(pending.pop_front());
          draw_gap(quiet_in, gap_left);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, compares every result beat
  always @(posedge clk) begin : result_check
    pixel_run_t want;
    int unsigned g;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_runs.size() == 0) begin
          report_mismatch($sformatf("unexpected beat idx %0d len %0d val %0d done %0d",
                                    out_pixel_index, out_run_length, out_pixel_value,
                                    out_frame_done));
        end else begin
          want = expected_runs.pop_front();
          if (out_pixel_index !== want.idx)
            report_mismatch($sformatf("pixel_index %0d, want %0d", out_pixel_index, want.idx));
          if (out_run_length !== want.len)
            report_mismatch($sformatf("run_length %0d, want %0d", out_run_length, want.len));
          if (out_pixel_value !== want.val)
            report_mismatch($sformatf("pixel_value %0d, want %0d", out_pixel_value, want.val));
          if (out_frame_done !== want.done)
            report_mismatch($sformatf("frame_done %0d, want %0d", out_frame_done, want.done));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        draw_gap(quiet_out, g);
        if (g == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          stall_left = g - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("bmp_rle8_decoder_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [BYTE_W-1:0] b);
    stream_byte_t s;
    s.code = b;
    s.fstart = start_next;
    s.hold = hold_next;
    start_next = 1'b0;
    hold_next = 1'b0;
    pending.push_back(s);
    items_made++;
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = v;
    else height_reg = v;
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // block idle: every byte taken, every run seen, then time for trailing moves
  task automatic settle();
    while (pending.size() != 0 || in_valid || expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly well-formed frames with random content; a share of noise and broken frames
  task automatic gen_stream(input int unsigned n, input int unsigned cmds_max,
                            input int unsigned delta_pct, input int unsigned down_max,
                            input bit fresh);
    int unsigned stop, ncmd, r, cnt;
    stop = items_made + n;
    while (items_made < stop) begin
      ncmd = $urandom_range(cmds_max, 1);
      if (fresh) begin
        start_next = 1'b1;
        hold_next = ($urandom_range(3, 0) == 0);
      end
      fresh = 1'b1;
      repeat (ncmd) begin
        r = $urandom_range(99, 0);
        if (r < delta_pct) begin
          queue_byte(ESC_MARK);
          queue_byte(ESC_DELTA);
          queue_byte(rand_byte(0, 255));
          queue_byte(rand_byte(0, down_max));
        end else begin
          r = $urandom_range(99, 0);
          if (r < 45) begin
            cnt = $urandom_range(1, 0) ? $urandom_range(16, 1) : $urandom_range(255, 1);
            queue_byte(8'(cnt));
            queue_byte(rand_byte(0, 255));
          end else if (r < 70) begin
            cnt = ($urandom_range(19, 0) == 0) ? $urandom_range(255, 3) : $urandom_range(10, 3);
            queue_byte(ESC_MARK);
            queue_byte(8'(cnt));
            repeat (cnt) queue_byte(rand_byte(0, 255));
            if (cnt[0]) queue_byte(rand_byte(0, 255));
          end else if (r < 85) begin
            queue_byte(ESC_MARK);
            queue_byte(ESC_EOL);
          end else if (r < 90) begin
            queue_byte(ESC_MARK);
            queue_byte(ESC_EOB);
          end else begin
            start_next = ($urandom_range(7, 0) == 0);
            queue_byte(rand_byte(0, 255));
          end
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every command kind, pad, row-end cases, clip, ignored tail, end of bitmap
    set_frame(13'd8, 13'd8);
    start_next = 1'b1;
    queue_byte(8'h03); queue_byte(8'hAA);
    queue_byte(ESC_MARK); queue_byte(8'h03);
    queue_byte(8'h55); queue_byte(8'h66); queue_byte(8'h77); queue_byte(8'h00);
    queue_byte(ESC_MARK); queue_byte(ESC_EOL);
    queue_byte(ESC_MARK); queue_byte(ESC_EOL);
    queue_byte(8'h08); queue_byte(8'h01);
    hold_next = 1'b1;
    queue_byte(ESC_MARK); queue_byte(ESC_EOL);
    queue_byte(ESC_MARK); queue_byte(ESC_DELTA); queue_byte(8'h03); queue_byte(8'h01);
    queue_byte(8'hFF); queue_byte(8'hFF);
    queue_byte(8'h80);
    start_next = 1'b1;
    queue_byte(ESC_MARK); queue_byte(ESC_EOB);
    settle();

    set_frame(13'd0, 13'd0);
    gen_stream(60, 3, 10, 2, 1'b1);
    settle();

    set_frame(13'd13, 13'd7);
    gen_stream(200, 30, 15, 3, 1'b1);
    settle();

    set_frame(13'd4096, 13'd4096);
    gen_stream(200, 60, 45, 255, 1'b1);
    settle();

    set_frame(13'd8191, 13'd8191);
    gen_stream(100, 60, 45, 255, 1'b1);
    settle();

    // width change in the middle of a frame
    set_frame(13'd100, 13'd50);
    gen_stream(150, 40, 15, 5, 1'b1);
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd37);
    gen_stream(60, 40, 15, 5, 1'b0);
    settle();

    // column carried across a narrower width, then a frame shrunk below the position
    start_next = 1'b1;
    queue_byte(8'h40); queue_byte(8'h22);
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd10);
    queue_byte(8'h05); queue_byte(8'h33);
    queue_byte(ESC_MARK); queue_byte(ESC_EOL);
    settle();
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    queue_byte(8'h07); queue_byte(8'h09);
    settle();

    set_frame(13'd1, 13'd4096);
    gen_stream(80, 30, 15, 255, 1'b1);
    settle();

    set_frame(13'd4096, 13'd1);
    gen_stream(80, 20, 15, 2, 1'b1);
    settle();

    if (fail_count == 0) begin
      $display("bmp_rle8_decoder_tb OK");
    end else begin
      $display("bmp_rle8_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule
